// File: rtl/core/krb_pkg.sv
`timescale 1ns / 1ps

package krb_pkg;

	// defaults for the top-level parameters
	localparam int CODE_SPACE_DEF   = 256;
	localparam int REPORT_SLOTS_DEF = 6;

	// fixed field widths
	localparam int CMD_W      = 3;
	localparam int CODE_W     = 8;
	localparam int COUNT_W    = 3;
	localparam int KEY_FIELDS = 6;

	// bitmap word: 16 codes per memory row
	localparam int WORD_W = 16;
	localparam int BIT_W  = 4;

	typedef enum logic [CMD_W-1:0] {
		CMD_KEY_PRESS   = 3'd0,
		CMD_KEY_RELEASE = 3'd1,
		CMD_MOD_PRESS   = 3'd2,
		CMD_MOD_RELEASE = 3'd3,
		CMD_REPORT      = 3'd4
	} cmd_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MODIFY,
		ST_LOAD,
		ST_PICK,
		ST_DONE
	} state_t;

	typedef logic [CODE_W-1:0] code_t;
	typedef code_t key_arr_t [KEY_FIELDS];

	// picker control from the sequencer
	typedef struct packed {
		logic clear;
		logic load;
		logic pick;
	} pick_ctl_t;

	// picker status back to the sequencer
	typedef struct packed {
		logic nz;
		logic full;
	} pick_stat_t;

endpackage

// File: rtl/core/krb_in_if.sv
`timescale 1ns / 1ps

interface krb_in_if;
	import krb_pkg::*;

	logic              valid;
	logic              ready;
	logic [CMD_W-1:0]  command;
	logic [CODE_W-1:0] code;

	modport source (output valid, output command, output code, input ready);
	modport sink   (input valid, input command, input code, output ready);
endinterface

// File: rtl/core/krb_out_if.sv
`timescale 1ns / 1ps

interface krb_out_if;
	import krb_pkg::*;

	logic               valid;
	logic               ready;
	logic [CODE_W-1:0]  modifier_byte;
	logic [CODE_W-1:0]  report_key_0;
	logic [CODE_W-1:0]  report_key_1;
	logic [CODE_W-1:0]  report_key_2;
	logic [CODE_W-1:0]  report_key_3;
	logic [CODE_W-1:0]  report_key_4;
	logic [CODE_W-1:0]  report_key_5;
	logic [COUNT_W-1:0] key_count;

	modport source (
		output valid, output modifier_byte,
		output report_key_0, output report_key_1, output report_key_2,
		output report_key_3, output report_key_4, output report_key_5,
		output key_count, input ready
	);
	modport sink (
		input valid, input modifier_byte,
		input report_key_0, input report_key_1, input report_key_2,
		input report_key_3, input report_key_4, input report_key_5,
		input key_count, output ready
	);
endinterface

// File: rtl/core/krb_ram.sv
`timescale 1ns / 1ps

module krb_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 16,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// File: rtl/core/krb_picker.sv
`timescale 1ns / 1ps

// Holds one bitmap word and peels its lowest set bit into the next key slot.
module krb_picker #(
	parameter int SLOT_LIM = 6
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  krb_pkg::pick_ctl_t            ctl,
	input  logic [krb_pkg::WORD_W-1:0]    word,
	input  logic [krb_pkg::CODE_W-1:0]    word_base,
	output krb_pkg::pick_stat_t           stat,
	output krb_pkg::key_arr_t             keys,
	output logic [krb_pkg::COUNT_W-1:0]   count
);
	import krb_pkg::*;

	logic [WORD_W-1:0]  word_q;
	logic [CODE_W-1:0]  base_q;
	logic [COUNT_W-1:0] count_q;
	key_arr_t           keys_q;
	logic [WORD_W-1:0]  low;
	logic [BIT_W-1:0]   bit_idx;

	// isolate lowest set bit, then encode it
	always_comb begin
		low     = word_q & (~word_q + 1'b1);
		bit_idx = '0;
		for (int i = 0; i < WORD_W; i++) begin
			if (low[i]) begin
				bit_idx = bit_idx | BIT_W'(i);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (ctl.clear) begin
			count_q <= '0;
		end else if (ctl.pick) begin
			count_q <= count_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.clear) begin
			for (int k = 0; k < KEY_FIELDS; k++) begin
				keys_q[k] <= '0;
			end
		end else if (ctl.pick) begin
			keys_q[count_q] <= base_q | CODE_W'(bit_idx);
		end
		if (ctl.load) begin
			word_q <= word;
			base_q <= word_base;
		end else if (ctl.pick) begin
			word_q <= word_q & ~low;
		end
	end

	assign stat.nz   = |word_q;
	assign stat.full = (count_q == COUNT_W'(SLOT_LIM));
	assign keys      = keys_q;
	assign count     = count_q;

endmodule

// File: rtl/core/keyboard_report_builder.sv
`timescale 1ns / 1ps

// Boot-keyboard report builder. Each request on key_evt carries a command:
// key press / release set or clear one keycode in a 256-code held set, modifier
// press / release OR in or clear bits of the held modifier byte, and a report
// command produces one result on key_report: the modifier byte, the lowest held
// keycodes in ascending order (up to min(REPORT_SLOTS, 6), unused slots zero)
// and the number of filled slots. No other command produces a result; codes
// 5..7 are ignored, as are key codes at or above CODE_SPACE. The held set lives
// in a single-port-read RAM of 16-bit rows, one request at a time. A key press
// or release reads its row, then writes it back. A report reads the rows in
// order from row 0, loads each into the picker and takes its set bits lowest
// first, stopping after the last row or once the slots are full. Rows carry
// valid flags cleared at reset, so no clearing pass is needed: the block takes
// requests straight after reset. A finished report sits in an output register,
// so further key and modifier requests are taken while it waits.
module keyboard_report_builder #(
	parameter int CODE_SPACE   = krb_pkg::CODE_SPACE_DEF,
	parameter int REPORT_SLOTS = krb_pkg::REPORT_SLOTS_DEF
) (
	input logic    clk,
	input logic    arst_n,
	krb_in_if.sink   key_evt,
	krb_out_if.source key_report
);
	import krb_pkg::*;

	localparam int DEPTH    = (CODE_SPACE + WORD_W - 1) / WORD_W;
	localparam int AW       = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int SLOT_LIM = (REPORT_SLOTS < KEY_FIELDS) ? REPORT_SLOTS : KEY_FIELDS;

	// sequencer
	state_t state_q, state_d;

	// held modifier byte
	logic [CODE_W-1:0] mod_q;

	// key update held across the read-modify-write
	logic [AW-1:0]     upd_addr_q;
	logic [BIT_W-1:0]  upd_bit_q;
	logic              upd_set_q;

	// scan row pointer
	logic [AW-1:0]     scan_addr_q;

	// row valid flags; a row never written reads as all clear
	logic [DEPTH-1:0]  row_vld_q;
	logic              rd_vld_s1;

	// RAM port signals
	logic              ram_we, ram_re;
	logic [AW-1:0]     ram_waddr, ram_raddr;
	logic [WORD_W-1:0] ram_wdata, ram_rdata, row_word;

	// picker
	pick_ctl_t         pctl;
	pick_stat_t        pstat;
	key_arr_t          pkeys;
	logic [COUNT_W-1:0] pcount;

	// output register
	logic               out_vld_q;
	logic [CODE_W-1:0]  out_mod_q;
	key_arr_t           out_keys_q;
	logic [COUNT_W-1:0] out_cnt_q;

	logic   accept, out_free, in_range, last_row;
	cmd_t   cmd;

	assign accept   = key_evt.valid && key_evt.ready;
	assign cmd      = cmd_t'(key_evt.command);
	assign in_range = {1'b0, key_evt.code} < 9'(CODE_SPACE);
	assign last_row = (scan_addr_q == AW'(DEPTH - 1));
	assign out_free = !out_vld_q || key_report.ready;
	assign row_word = rd_vld_s1 ? ram_rdata : '0;

	krb_ram #(
		.WIDTH (WORD_W),
		.DEPTH (DEPTH),
		.AW    (AW)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	krb_picker #(
		.SLOT_LIM (SLOT_LIM)
	) u_picker (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctl       (pctl),
		.word      (row_word),
		.word_base (CODE_W'({scan_addr_q, {BIT_W{1'b0}}})),
		.stat      (pstat),
		.keys      (pkeys),
		.count     (pcount)
	);

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					unique case (cmd)
						CMD_KEY_PRESS, CMD_KEY_RELEASE: begin
							if (in_range) state_d = ST_MODIFY;
						end
						CMD_REPORT: state_d = ST_LOAD;
						default: state_d = ST_IDLE;
					endcase
				end
			end
			ST_MODIFY: state_d = ST_IDLE;
			ST_LOAD:   state_d = ST_PICK;
			ST_PICK: begin
				if (pstat.nz && !pstat.full) begin
					state_d = ST_PICK;
				end else if (pstat.full || last_row) begin
					state_d = ST_DONE;
				end else begin
					state_d = ST_LOAD;
				end
			end
			ST_DONE: begin
				if (out_free) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// outputs of the sequencer
	always_comb begin
		ram_re     = 1'b0;
		ram_raddr  = upd_addr_q;
		ram_we     = 1'b0;
		ram_waddr  = upd_addr_q;
		ram_wdata  = row_word;
		pctl       = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (accept && cmd == CMD_REPORT) begin
					ram_re    = 1'b1;
					ram_raddr = '0;
					pctl.clear = 1'b1;
				end else if (accept && in_range &&
				             (cmd == CMD_KEY_PRESS || cmd == CMD_KEY_RELEASE)) begin
					ram_re    = 1'b1;
					ram_raddr = AW'(key_evt.code >> BIT_W);
				end
			end
			ST_MODIFY: begin
				ram_we = 1'b1;
				if (upd_set_q) begin
					ram_wdata = row_word | (WORD_W'(1) << upd_bit_q);
				end else begin
					ram_wdata = row_word & ~(WORD_W'(1) << upd_bit_q);
				end
			end
			ST_LOAD: pctl.load = 1'b1;
			ST_PICK: begin
				if (pstat.nz && !pstat.full) begin
					pctl.pick = 1'b1;
				end else if (!pstat.full && !last_row) begin
					ram_re    = 1'b1;
					ram_raddr = scan_addr_q + 1'b1;
				end
			end
			ST_DONE: ;
			default: ;
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			mod_q       <= '0;
			row_vld_q   <= '0;
			rd_vld_s1   <= 1'b0;
			scan_addr_q <= '0;
			out_vld_q   <= 1'b0;
		end else begin
			state_q <= state_d;
			if (ram_re) begin
				rd_vld_s1 <= row_vld_q[ram_raddr];
			end
			if (ram_we) begin
				row_vld_q[ram_waddr] <= 1'b1;
			end
			if (accept && cmd == CMD_MOD_PRESS) begin
				mod_q <= mod_q | key_evt.code;
			end else if (accept && cmd == CMD_MOD_RELEASE) begin
				mod_q <= mod_q & ~key_evt.code;
			end
			if (state_q == ST_IDLE && accept && cmd == CMD_REPORT) begin
				scan_addr_q <= '0;
			end else if (ram_re && state_q == ST_PICK) begin
				scan_addr_q <= scan_addr_q + 1'b1;
			end
			if (state_q == ST_DONE && out_free) begin
				out_vld_q <= 1'b1;
			end else if (key_report.ready) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && accept) begin
			upd_addr_q <= AW'(key_evt.code >> BIT_W);
			upd_bit_q  <= key_evt.code[BIT_W-1:0];
			upd_set_q  <= (cmd == CMD_KEY_PRESS);
		end
		if (state_q == ST_DONE && out_free) begin
			out_mod_q  <= mod_q;
			out_keys_q <= pkeys;
			out_cnt_q  <= pcount;
		end
	end

	assign key_evt.ready = (state_q == ST_IDLE);

	assign key_report.valid         = out_vld_q;
	assign key_report.modifier_byte = out_mod_q;
	assign key_report.report_key_0  = out_keys_q[0];
	assign key_report.report_key_1  = out_keys_q[1];
	assign key_report.report_key_2  = out_keys_q[2];
	assign key_report.report_key_3  = out_keys_q[3];
	assign key_report.report_key_4  = out_keys_q[4];
	assign key_report.report_key_5  = out_keys_q[5];
	assign key_report.key_count     = out_cnt_q;

	// a report never claims more keys than the slot limit
	a_count_lim: assert property (@(posedge clk) disable iff (!arst_n)
		key_report.valid |-> key_report.key_count <= COUNT_W'(SLOT_LIM))
		else $error("key_count beyond slot limit");

	// an empty report has a zero first slot
	a_empty_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(key_report.valid && key_report.key_count == '0) |-> key_report.report_key_0 == '0)
		else $error("empty report with a key");

	// a new result only ever comes from the end of a scan
	a_out_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_vld_q) |-> $past(state_q) == ST_DONE)
		else $error("result raised outside scan end");

	// RAM write only as the second half of a key update
	a_we_rmw: assert property (@(posedge clk) disable iff (!arst_n)
		ram_we |-> $past(state_q) == ST_IDLE && $past(ram_re))
		else $error("write without preceding read");

endmodule

// File: dv/krb_report_checker.sv
`timescale 1ns / 1ps

// Watches both channels, keeps its own picture of the held keys and modifiers,
// predicts each report and compares it with what comes out.
module krb_report_checker #(
	parameter int CODE_SPACE   = krb_pkg::CODE_SPACE_DEF,
	parameter int REPORT_SLOTS = krb_pkg::REPORT_SLOTS_DEF
) (
	input  logic clk,
	input  logic arst_n,
	krb_in_if    key_evt,
	krb_out_if   key_report,
	output int   mismatches,
	output int   reports_due,
	output int   requests_taken,
	output int   reports_checked,
	output int   most_held
);
	import krb_pkg::*;

	typedef struct packed {
		code_t                  mods;
		code_t [KEY_FIELDS-1:0] keys;
		logic  [COUNT_W-1:0]    count;
	} key_report_t;

	logic        held_keys [CODE_SPACE];
	code_t       held_mods;
	int          held_total;
	key_report_t pending_reports [$];

	// lowest held codes first, capped by the slot count and the six fields
	function automatic key_report_t scan_held_keys();
		key_report_t r;
		int          filled;
		int          slot_cap;
		r        = '0;
		r.mods   = held_mods;
		slot_cap = (REPORT_SLOTS < KEY_FIELDS) ? REPORT_SLOTS : KEY_FIELDS;
		filled   = 0;
		for (int c = 0; c < CODE_SPACE; c++) begin
			if (held_keys[c] && filled < slot_cap) begin
				r.keys[filled] = code_t'(c);
				filled++;
			end
		end
		r.count = COUNT_W'(filled);
		return r;
	endfunction

	// four-state compare, so an unknown on the output never passes
	task automatic check_field(input string name, input logic [31:0] want,
	                           input logic [31:0] got);
		if (want !== got) begin
			$error("%s: expected 0x%0h, got 0x%0h", name, want, got);
			mismatches++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		key_report_t want;
		if (!arst_n) begin
			foreach (held_keys[i])
				held_keys[i] = 1'b0;
			held_mods       = '0;
			held_total      = 0;
			pending_reports.delete();
			mismatches      = 0;
			requests_taken  = 0;
			reports_checked = 0;
			most_held       = 0;
			reports_due     <= 0;
		end else begin
			// results first, so a stray report is never matched to one queued now
			if (key_report.valid && key_report.ready) begin
				if (pending_reports.size() == 0) begin
					$error("report with no request outstanding");
					mismatches++;
				end else begin
					want = pending_reports.pop_front();
					check_field("modifier_byte", want.mods,    key_report.modifier_byte);
					check_field("report_key_0",  want.keys[0], key_report.report_key_0);
					check_field("report_key_1",  want.keys[1], key_report.report_key_1);
					check_field("report_key_2",  want.keys[2], key_report.report_key_2);
					check_field("report_key_3",  want.keys[3], key_report.report_key_3);
					check_field("report_key_4",  want.keys[4], key_report.report_key_4);
					check_field("report_key_5",  want.keys[5], key_report.report_key_5);
					check_field("key_count",     want.count,   key_report.key_count);
					reports_checked++;
				end
			end
			if (key_evt.valid && key_evt.ready) begin
				requests_taken++;
				case (key_evt.command)
				CMD_KEY_PRESS: begin
					if (key_evt.code < CODE_SPACE && !held_keys[key_evt.code]) begin
						held_keys[key_evt.code] = 1'b1;
						held_total++;
					end
				end
				CMD_KEY_RELEASE: begin
					if (key_evt.code < CODE_SPACE && held_keys[key_evt.code]) begin
						held_keys[key_evt.code] = 1'b0;
						held_total--;
					end
				end
				CMD_MOD_PRESS:   held_mods = held_mods | key_evt.code;
				CMD_MOD_RELEASE: held_mods = held_mods & ~key_evt.code;
				CMD_REPORT:      pending_reports.push_back(scan_held_keys());
				default: ;
				endcase
				if (held_total > most_held)
					most_held = held_total;
			end
			reports_due <= pending_reports.size();
		end
	end

endmodule

// File: dv/keyboard_report_builder_tb.sv
`timescale 1ns / 1ps

// Stimulus and verdict for the report builder. Prediction and comparison live
// in the checker beside the block; this module only makes requests, works the
// receiver's ready and decides the outcome.
module keyboard_report_builder_tb;
	import krb_pkg::*;

	localparam int CODE_SPACE   = CODE_SPACE_DEF;
	localparam int REPORT_SLOTS = REPORT_SLOTS_DEF;

	// commands the block must swallow without a trace
	localparam logic [CMD_W-1:0] CMD_SPARE_5 = 3'd5;
	localparam logic [CMD_W-1:0] CMD_SPARE_6 = 3'd6;
	localparam logic [CMD_W-1:0] CMD_SPARE_7 = 3'd7;

	// bound on the worst report scan (rows, slots and handover); add margin
	localparam int DRAIN_CYCLES = 2 * CODE_SPACE / WORD_W + REPORT_SLOTS + 2 + 20;
	localparam int PHASE_ITEMS  = 100;
	localparam int LONG_HOLD    = 300;

	logic clk;
	logic arst_n;

	krb_in_if  key_evt ();
	krb_out_if key_report ();

	// idling mix, changed per phase
	int src_idle_pct;
	int sink_stall_pct;
	bit hold_request;

	// rough view of what is held, only to steer stimulus (not for checking)
	bit stim_held [CODE_SPACE];
	int stim_held_n;

	int mismatches;
	int reports_due;
	int requests_taken;
	int reports_checked;
	int most_held;

	keyboard_report_builder #(
		.CODE_SPACE   (CODE_SPACE),
		.REPORT_SLOTS (REPORT_SLOTS)
	) dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.key_evt    (key_evt),
		.key_report (key_report)
	);

	krb_report_checker #(
		.CODE_SPACE   (CODE_SPACE),
		.REPORT_SLOTS (REPORT_SLOTS)
	) u_checker (
		.clk             (clk),
		.arst_n          (arst_n),
		.key_evt         (key_evt),
		.key_report      (key_report),
		.mismatches      (mismatches),
		.reports_due     (reports_due),
		.requests_taken  (requests_taken),
		.reports_checked (reports_checked),
		.most_held       (most_held)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// hard stop: well beyond the slowest legal run
	initial begin
		#5_000_000;
		$display("FAIL");
		$finish;
	end

	// Receiver. Random stalls per the current mix; on request a long hold-off,
	// counted here, so the output register fills and key_evt backs up.
	initial begin
		key_report.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_request) begin
				hold_request = 1'b0;
				key_report.ready <= 1'b0;
				repeat (LONG_HOLD - 1) @(posedge clk);
			end else begin
				key_report.ready <= ($urandom_range(99) >= sink_stall_pct);
			end
		end
	end

	// One request. Idle cycles go in front, so valid stays up across
	// back-to-back requests and is never dropped and raised in one step.
	task automatic send(input logic [CMD_W-1:0] cmd, input code_t k);
		while ($urandom_range(99) < src_idle_pct) begin
			key_evt.valid <= 1'b0;
			@(posedge clk);
		end
		key_evt.valid   <= 1'b1;
		key_evt.command <= cmd;
		key_evt.code    <= k;
		@(posedge clk);
		while (!key_evt.ready)
			@(posedge clk);
	endtask

	task automatic press(input code_t k);
		send(CMD_KEY_PRESS, k);
		if (!stim_held[k]) begin
			stim_held[k] = 1'b1;
			stim_held_n++;
		end
	endtask

	task automatic release_key(input code_t k);
		send(CMD_KEY_RELEASE, k);
		if (stim_held[k]) begin
			stim_held[k] = 1'b0;
			stim_held_n--;
		end
	endtask

	// Mostly key traffic around the six-slot boundary, some modifier churn and
	// reports, now and then a spare command that should do nothing.
	task automatic random_request();
		int    pick;
		code_t k;
		if ($urandom_range(99) < 4)
			send(CMD_W'($urandom_range(CMD_SPARE_7, CMD_SPARE_5)), code_t'($urandom));
		pick = $urandom_range(99);
		if (pick < 18) begin
			send(CMD_REPORT, code_t'($urandom));
		end else if (pick < 28) begin
			send(CMD_MOD_PRESS, code_t'($urandom));
		end else if (pick < 36) begin
			send(CMD_MOD_RELEASE, code_t'($urandom));
		end else if (stim_held_n > 0 && $urandom_range(9) < stim_held_n) begin
			k = code_t'($urandom);
			// one in ten releases hits whatever code came up, held or not
			if ($urandom_range(9) != 0)
				while (!stim_held[k])
					k++;
			release_key(k);
		end else begin
			case ($urandom_range(3))
			0:       k = code_t'($urandom_range(15));
			1:       k = code_t'($urandom_range(255, 240));
			default: k = code_t'($urandom);
			endcase
			press(k);
		end
	endtask

	// Let every expected report come out, then give the block its scan time.
	task automatic drain();
		key_evt.valid <= 1'b0;
		@(posedge clk);
		while (reports_due != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	initial begin
		arst_n          <= 1'b0;
		key_evt.valid   <= 1'b0;
		key_evt.command <= CMD_KEY_PRESS;
		key_evt.code    <= '0;
		src_idle_pct   = 0;
		sink_stall_pct = 0;
		hold_request   = 1'b0;
		stim_held_n    = 0;
		foreach (stim_held[i])
			stim_held[i] = 1'b0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: empty report, keycode zero and 0xFF held, full modifier byte
		send(CMD_REPORT, 8'h00);
		press(8'h00);
		press(8'hFF);
		send(CMD_MOD_PRESS, 8'hFF);
		send(CMD_REPORT, 8'hFF);
		send(CMD_MOD_RELEASE, 8'h0F);
		// seven keys held: the highest must fall off the end of the report
		press(8'h80);
		press(8'h7F);
		press(8'h55);
		press(8'hAA);
		press(8'h55);
		press(8'h01);
		send(CMD_REPORT, 8'h00);
		// spare commands carry no effect and no report
		send(CMD_SPARE_5, 8'hFF);
		send(CMD_SPARE_6, 8'h00);
		send(CMD_SPARE_7, 8'hAA);
		// repeated release, release of a key never pressed
		release_key(8'h00);
		release_key(8'h00);
		release_key(8'h33);
		send(CMD_MOD_RELEASE, 8'hF0);
		send(CMD_REPORT, 8'h00);
		release_key(8'hFF);
		release_key(8'h80);
		send(CMD_REPORT, 8'h55);
		drain();

		// random phases: free flow, slow sender, slow receiver, both a little
		for (int phase = 0; phase < 4; phase++) begin
			case (phase)
			0: begin src_idle_pct = 0;  sink_stall_pct = 0;  end
			1: begin src_idle_pct = 64; sink_stall_pct = 0;  end
			2: begin src_idle_pct = 0;  sink_stall_pct = 64; end
			default: begin src_idle_pct = 10; sink_stall_pct = 10; end
			endcase
			repeat (PHASE_ITEMS) random_request();
			drain();
		end

		// back-pressure: receiver shut for a long stretch while reports keep coming
		src_idle_pct   = 0;
		sink_stall_pct = 10;
		hold_request   = 1'b1;
		repeat (40) begin
			send(CMD_REPORT, code_t'($urandom));
			random_request();
		end
		drain();

		$display("Covered %0d requests on key_evt and %0d checked reports; %0d keys held at most.",
			requests_taken, reports_checked, most_held);
		$display("Idling mixes: none, slow sender, slow receiver, both, and a %0d-cycle hold-off.",
			LONG_HOLD);
		if (reports_due != 0)
			$error("%0d reports never arrived", reports_due);
		if (mismatches == 0 && reports_due == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end

endmodule

// File: filelist.f
rtl/core/krb_pkg.sv
rtl/core/krb_in_if.sv
rtl/core/krb_out_if.sv
rtl/core/krb_ram.sv
rtl/core/krb_picker.sv
rtl/core/keyboard_report_builder.sv
dv/krb_report_checker.sv
dv/keyboard_report_builder_tb.sv
